FILE: design/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg
// Shared constants, register codes and sizing helpers for the converging
// flow test pipeline.
// ----------------------------------------------------------------------------
package cft_pkg;

   // default width of one velocity difference (signed Q16.16 at 32)
   localparam int DIFF_BITS_DEF = 32;

   // inverse cell width registers, unsigned Q16.16
   localparam int INV_W = 32;
   localparam logic [INV_W-1:0] INV_WIDTH_RESET = 32'h0001_0000;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHECK_ENABLE = 2'd0,
      CSR_INV_WIDTH_X  = 2'd1,
      CSR_INV_WIDTH_Y  = 2'd2,
      CSR_INV_WIDTH_Z  = 2'd3
   } csr_index_type;

   // multiplier digit: 32 bits, plus one sign bit on the top digit
   localparam int DIG_W = 32;

   // digits needed for a signed operand of width w (w >= 2)
   function automatic int num_digits(input int w);
      return (w - 2) / DIG_W + 1;
   endfunction

endpackage

FILE: design/cft_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_mul
// Pipelined signed multiplier. One 33x33 digit product per stage is added
// into a full-width accumulator; operands travel down with the partial sum.
// ----------------------------------------------------------------------------
module cft_mul
   import cft_pkg::*;
#(
   parameter int A_W = 32,
   parameter int B_W = 33
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [A_W-1:0]     in_a,
   input  logic signed [B_W-1:0]     in_b,
   output logic signed [A_W+B_W-1:0] out_p
);

   localparam int NA   = num_digits(A_W);
   localparam int NB   = num_digits(B_W);
   localparam int NS   = NA * NB;
   localparam int P_W  = A_W + B_W;
   localparam int AX_W = NA * DIG_W + 1;
   localparam int BX_W = NB * DIG_W + 1;

   // operands entering each stage; entry 0 is the module input
   logic signed [A_W-1:0] a_stg [NS];
   logic signed [B_W-1:0] b_stg [NS];
   logic signed [P_W-1:0] acc_ff [NS];

   assign a_stg[0] = in_a;
   assign b_stg[0] = in_b;

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int DA = s % NA;
      localparam int DB = s / NA;
      localparam int SH = DIG_W * (DA + DB);

      logic signed [AX_W-1:0]      a_x;
      logic signed [BX_W-1:0]      b_x;
      logic signed [DIG_W:0]       dig_a;
      logic signed [DIG_W:0]       dig_b;
      logic signed [2*DIG_W+1:0]   pp;
      logic signed [P_W-1:0]       pp_sh;
      logic signed [P_W-1:0]       acc_in;

      assign a_x = AX_W'(a_stg[s]);
      assign b_x = BX_W'(b_stg[s]);

      // top digit carries the sign, lower digits are unsigned
      if (DA == NA - 1) begin : g_a_top
         assign dig_a = a_x[AX_W-1 -: DIG_W+1];
      end else begin : g_a_low
         assign dig_a = signed'({1'b0, a_x[DA*DIG_W +: DIG_W]});
      end

      if (DB == NB - 1) begin : g_b_top
         assign dig_b = b_x[BX_W-1 -: DIG_W+1];
      end else begin : g_b_low
         assign dig_b = signed'({1'b0, b_x[DB*DIG_W +: DIG_W]});
      end

      assign pp    = dig_a * dig_b;
      assign pp_sh = P_W'(pp) << SH;

      if (s == 0) begin : g_first
         assign acc_in = pp_sh;
      end else begin : g_next
         assign acc_in = acc_ff[s-1] + pp_sh;
      end

      // partial sum register
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s] <= acc_in;
         end
      end

      // operands follow the partial sum
      if (s < NS - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            if (en) begin
               a_stg[s+1] <= a_stg[s];
               b_stg[s+1] <= b_stg[s];
            end
         end
      end
   end

   assign out_p = acc_ff[NS-1];

endmodule

FILE: design/cft_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_delay
// Enabled shift line that keeps side data aligned with the multiplier
// pipelines.
// ----------------------------------------------------------------------------
module cft_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] in_d,
   output logic [W-1:0] out_d
);

   logic [W-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_d;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_d = data_ff[DEPTH-1];

endmodule

FILE: design/converging_flow_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// converging_flow_test
// Streams one grid cell per unstalled cycle and, if enabled, flags cells whose
// strain tensor has no positive eigenvalue (principal minors of -tensor >= 0).
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the nine signed velocity differences of one cell; a word
//   is taken on a clock edge with req_valid high and req_stall low.
//   rsp_converging returns one bit per cell, in order, under rsp_valid and
//   rsp_stall. csr_* writes check_enable and the three inverse widths; write
//   only while no cell is in flight.
// Pipeline: the valid shift register is LAT bits long, where
//   LAT = L1 + L2 + L3 + 4 and L1, L2, L3 are the stage counts of the
//   gradient, 2x2 minor and determinant multipliers (one 33x33 digit product
//   per stage). At DIFF_BITS = 32: L1 = 1, L2 = 4, L3 = 10.
// Throughput: one cell per cycle while no result is held under rsp_stall.
// Stall: the whole pipeline holds while a result waits under rsp_stall;
//   bubbles move on and a new word is taken whenever the output is free
//   or is being taken.
// Reset: empties the pipeline and loads check_enable = 0 and inverse
//   widths of 1.0.
// ----------------------------------------------------------------------------
module converging_flow_test
   import cft_pkg::*;
#(
   parameter int DIFF_BITS = DIFF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // cell input
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DIFF_BITS-1:0] req_dvx_along_x,
   input  logic signed [DIFF_BITS-1:0] req_dvx_along_y,
   input  logic signed [DIFF_BITS-1:0] req_dvx_along_z,
   input  logic signed [DIFF_BITS-1:0] req_dvy_along_x,
   input  logic signed [DIFF_BITS-1:0] req_dvy_along_y,
   input  logic signed [DIFF_BITS-1:0] req_dvy_along_z,
   input  logic signed [DIFF_BITS-1:0] req_dvz_along_x,
   input  logic signed [DIFF_BITS-1:0] req_dvz_along_y,
   input  logic signed [DIFF_BITS-1:0] req_dvz_along_z,
   // result
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_converging,
   // configuration
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   // widths: gradient/tensor, 2x2 minor, determinant term, determinant
   localparam int M_W   = DIFF_BITS + INV_W + 1;
   localparam int C_W   = 2 * M_W + 1;
   localparam int T_W   = M_W + C_W;
   localparam int DET_W = 3 * M_W + 3;

   localparam int L1  = num_digits(DIFF_BITS) * num_digits(INV_W + 1);
   localparam int L2  = num_digits(M_W) * num_digits(M_W);
   localparam int L3  = num_digits(M_W) * num_digits(C_W);
   localparam int LAT = L1 + L2 + L3 + 4;

   // product slots of the 2x2 multipliers
   localparam int NPROD   = 10;
   localparam int P_00_11 = 0;
   localparam int P_01_01 = 1;
   localparam int P_00_22 = 2;
   localparam int P_02_02 = 3;
   localparam int P_11_22 = 4;
   localparam int P_12_12 = 5;
   localparam int P_01_22 = 6;
   localparam int P_12_02 = 7;
   localparam int P_01_12 = 8;
   localparam int P_11_02 = 9;

   // configuration registers
   logic             check_enable_ff;
   logic [INV_W-1:0] inv_width_x_ff;
   logic [INV_W-1:0] inv_width_y_ff;
   logic [INV_W-1:0] inv_width_z_ff;

   // pipeline control
   logic           advance;
   logic [LAT-1:0] valid_ff;

   // datapath
   logic signed [DIFF_BITS-1:0] d_in [3][3];
   logic signed [INV_W:0]       w_ext [3];
   logic signed [M_W-1:0]       grad [3][3];
   logic signed [M_W-1:0]       m00_ff, m01_ff, m02_ff, m11_ff, m12_ff, m22_ff;
   logic                        diag_ok;
   logic signed [M_W-1:0]       sq_a [NPROD];
   logic signed [M_W-1:0]       sq_b [NPROD];
   logic signed [2*M_W-1:0]     prod2 [NPROD];
   logic [3*M_W:0]              m_dly_in, m_dly_out;
   logic                        diag_d;
   logic signed [M_W-1:0]       md00, md01, md02;
   logic signed [C_W-1:0]       minor01_ff, minor02_ff, c11_ff, c12_ff, c13_ff;
   logic                        flag_ok;
   logic                        flag_d;
   logic signed [M_W-1:0]       det_a [3];
   logic signed [C_W-1:0]       det_b [3];
   logic signed [T_W-1:0]       term [3];
   logic signed [DET_W-1:0]     det_ff;
   logic                        rsp_converging_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b0;
         inv_width_x_ff  <= INV_WIDTH_RESET;
         inv_width_y_ff  <= INV_WIDTH_RESET;
         inv_width_z_ff  <= INV_WIDTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CHECK_ENABLE: check_enable_ff <= csr_data[0];
            CSR_INV_WIDTH_X:  inv_width_x_ff  <= csr_data[INV_W-1:0];
            CSR_INV_WIDTH_Y:  inv_width_y_ff  <= csr_data[INV_W-1:0];
            CSR_INV_WIDTH_Z:  inv_width_z_ff  <= csr_data[INV_W-1:0];
         endcase
      end
   end

   // the pipeline moves unless a result is held at the output
   assign advance   = !valid_ff[LAT-1] || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // gradients g_ij = d_ij * w_j
   assign d_in[0][0] = req_dvx_along_x;
   assign d_in[0][1] = req_dvx_along_y;
   assign d_in[0][2] = req_dvx_along_z;
   assign d_in[1][0] = req_dvy_along_x;
   assign d_in[1][1] = req_dvy_along_y;
   assign d_in[1][2] = req_dvy_along_z;
   assign d_in[2][0] = req_dvz_along_x;
   assign d_in[2][1] = req_dvz_along_y;
   assign d_in[2][2] = req_dvz_along_z;

   assign w_ext[0] = signed'({1'b0, inv_width_x_ff});
   assign w_ext[1] = signed'({1'b0, inv_width_y_ff});
   assign w_ext[2] = signed'({1'b0, inv_width_z_ff});

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         cft_mul #(
            .A_W (DIFF_BITS),
            .B_W (INV_W + 1)
         ) u_grad_mul (
            .clock (clock),
            .en    (advance),
            .in_a  (d_in[i][j]),
            .in_b  (w_ext[j]),
            .out_p (grad[i][j])
         );
      end
   end

   // twice the strain tensor, upper triangle
   always_ff @(posedge clock) begin
      if (advance) begin
         m00_ff <= grad[0][0] + grad[0][0];
         m01_ff <= grad[0][1] + grad[1][0];
         m02_ff <= grad[0][2] + grad[2][0];
         m11_ff <= grad[1][1] + grad[1][1];
         m12_ff <= grad[1][2] + grad[2][1];
         m22_ff <= grad[2][2] + grad[2][2];
      end
   end

   assign diag_ok = (m00_ff[M_W-1] || m00_ff == '0) &&
                    (m11_ff[M_W-1] || m11_ff == '0) &&
                    (m22_ff[M_W-1] || m22_ff == '0);

   // products for the 2x2 minors and the cofactors
   assign sq_a[P_00_11] = m00_ff;  assign sq_b[P_00_11] = m11_ff;
   assign sq_a[P_01_01] = m01_ff;  assign sq_b[P_01_01] = m01_ff;
   assign sq_a[P_00_22] = m00_ff;  assign sq_b[P_00_22] = m22_ff;
   assign sq_a[P_02_02] = m02_ff;  assign sq_b[P_02_02] = m02_ff;
   assign sq_a[P_11_22] = m11_ff;  assign sq_b[P_11_22] = m22_ff;
   assign sq_a[P_12_12] = m12_ff;  assign sq_b[P_12_12] = m12_ff;
   assign sq_a[P_01_22] = m01_ff;  assign sq_b[P_01_22] = m22_ff;
   assign sq_a[P_12_02] = m12_ff;  assign sq_b[P_12_02] = m02_ff;
   assign sq_a[P_01_12] = m01_ff;  assign sq_b[P_01_12] = m12_ff;
   assign sq_a[P_11_02] = m11_ff;  assign sq_b[P_11_02] = m02_ff;

   for (genvar p = 0; p < NPROD; p++) begin : g_prod2
      cft_mul #(
         .A_W (M_W),
         .B_W (M_W)
      ) u_minor_mul (
         .clock (clock),
         .en    (advance),
         .in_a  (sq_a[p]),
         .in_b  (sq_b[p]),
         .out_p (prod2[p])
      );
   end

   // first row and diagonal flag wait for the minors
   assign m_dly_in = {diag_ok, m00_ff, m01_ff, m02_ff};

   cft_delay #(
      .W     (3 * M_W + 1),
      .DEPTH (L2 + 1)
   ) u_row_dly (
      .clock (clock),
      .en    (advance),
      .in_d  (m_dly_in),
      .out_d (m_dly_out)
   );

   assign diag_d = m_dly_out[3*M_W];
   assign md00   = m_dly_out[3*M_W-1 -: M_W];
   assign md01   = m_dly_out[2*M_W-1 -: M_W];
   assign md02   = m_dly_out[M_W-1:0];

   // 2x2 principal minors and cofactors
   always_ff @(posedge clock) begin
      if (advance) begin
         minor01_ff <= C_W'(prod2[P_00_11]) - C_W'(prod2[P_01_01]);
         minor02_ff <= C_W'(prod2[P_00_22]) - C_W'(prod2[P_02_02]);
         c11_ff     <= C_W'(prod2[P_11_22]) - C_W'(prod2[P_12_12]);
         c12_ff     <= C_W'(prod2[P_01_22]) - C_W'(prod2[P_12_02]);
         c13_ff     <= C_W'(prod2[P_01_12]) - C_W'(prod2[P_11_02]);
      end
   end

   assign flag_ok = diag_d && !minor01_ff[C_W-1] && !minor02_ff[C_W-1] && !c11_ff[C_W-1];

   cft_delay #(
      .W     (1),
      .DEPTH (L3 + 1)
   ) u_flag_dly (
      .clock (clock),
      .en    (advance),
      .in_d  (flag_ok),
      .out_d (flag_d)
   );

   // determinant terms, expanded along the first row
   assign det_a[0] = md00;  assign det_b[0] = c11_ff;
   assign det_a[1] = md01;  assign det_b[1] = c12_ff;
   assign det_a[2] = md02;  assign det_b[2] = c13_ff;

   for (genvar t = 0; t < 3; t++) begin : g_det
      cft_mul #(
         .A_W (M_W),
         .B_W (C_W)
      ) u_det_mul (
         .clock (clock),
         .en    (advance),
         .in_a  (det_a[t]),
         .in_b  (det_b[t]),
         .out_p (term[t])
      );
   end

   // determinant sum, then final decision into the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         det_ff            <= DET_W'(term[0]) - DET_W'(term[1]) + DET_W'(term[2]);
         rsp_converging_ff <= !check_enable_ff ||
                              (flag_d && (det_ff[DET_W-1] || det_ff == '0));
      end
   end

   assign rsp_valid      = valid_ff[LAT-1];
   assign rsp_converging = rsp_converging_ff;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: converging flow test bench
// Streams grid cells into converging_flow_test and checks every verdict
// against an exact wide-integer strain tensor minor check kept in the bench.
// Covers the bypass, the boundary tensors (zero, rank one, rank two), fails
// found only by the determinant, width extremes and register masking, then
// long random runs with both sides idling and stalling at random.
// ----------------------------------------------------------------------------
module tb
   import cft_pkg::*;
();

   localparam int DIFF_BITS    = DIFF_BITS_DEF;
   localparam int WIDE         = 256;      // no minor comes close to this
   localparam int PIPE_LAT     = 18;
   localparam int DRAIN_CYCLES = PIPE_LAT + 6;
   localparam int CYCLE_LIMIT  = 300000;

   // one cell: [velocity component][difference direction]
   typedef logic [2:0][2:0][DIFF_BITS-1:0] cell_type;
   typedef logic signed [WIDE-1:0] wide_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [DIFF_BITS-1:0]  req_d [3][3];
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_converging;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // bench copy of the registers
   bit                    cfg_enable;
   logic [INV_W-1:0]      cfg_inv_width [3];

   bit                    pending_verdicts [$];
   int unsigned           failures;
   int unsigned           cycle_count;
   int                    idle_pct;

   always #5 clock = ~clock;

   converging_flow_test #(.DIFF_BITS(DIFF_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_dvx_along_x (req_d[0][0]),
      .req_dvx_along_y (req_d[0][1]),
      .req_dvx_along_z (req_d[0][2]),
      .req_dvy_along_x (req_d[1][0]),
      .req_dvy_along_y (req_d[1][1]),
      .req_dvy_along_z (req_d[1][2]),
      .req_dvz_along_x (req_d[2][0]),
      .req_dvz_along_y (req_d[2][1]),
      .req_dvz_along_z (req_d[2][2]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_converging  (rsp_converging),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ---------------------------------------------------------------------
   // Verdict: -S negative... i.e. all principal minors of -(2S) >= 0
   // ---------------------------------------------------------------------
   function automatic bit converging_verdict(input cell_type c);
      wide_type w [3];
      wide_type g [3][3];
      wide_type m [3][3];
      wide_type c11, c12, c13, det;
      bit    ok;
      if (!cfg_enable) return 1'b1;
      for (int j = 0; j < 3; j++) w[j] = $signed({1'b0, cfg_inv_width[j]});
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            g[i][j] = $signed(c[i][j]) * w[j];
      // twice the strain tensor, so no halving is needed
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = g[i][j] + g[j][i];
      ok = (m[0][0] <= 0) && (m[1][1] <= 0) && (m[2][2] <= 0);
      // even order minors keep their sign under negation
      if (ok && (m[0][0] * m[1][1] - m[0][1] * m[0][1]) < 0) ok = 1'b0;
      if (ok && (m[0][0] * m[2][2] - m[0][2] * m[0][2]) < 0) ok = 1'b0;
      if (ok && (m[1][1] * m[2][2] - m[1][2] * m[1][2]) < 0) ok = 1'b0;
      if (ok) begin
         c11 = m[1][1] * m[2][2] - m[1][2] * m[1][2];
         c12 = m[0][1] * m[2][2] - m[1][2] * m[0][2];
         c13 = m[0][1] * m[1][2] - m[1][1] * m[0][2];
         det = m[0][0] * c11 - m[0][1] * c12 + m[0][2] * c13;
         if (det > 0) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic int draw_gap();
      if ($urandom_range(0, 99) < idle_pct) return int'($urandom_range(0, 13));
      return 0;
   endfunction

   function automatic cell_type uniform_cell(input logic [DIFF_BITS-1:0] word);
      cell_type c;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            c[i][j] = word;
      return c;
   endfunction

   function automatic logic [DIFF_BITS-1:0] noise_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return $urandom_range(0, 15) - 8;
         default: return $urandom();
      endcase
   endfunction

   // Mostly -(u u' + v v') plus a rotation part that cancels in the
   // symmetric tensor; some get a nudge of one entry, some are pure noise.
   function automatic cell_type random_cell();
      cell_type           c;
      logic signed [31:0] u [3];
      logic signed [31:0] v [3];
      logic signed [31:0] s, a;
      int                 kind, i, j;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
               c[i][j] = noise_word();
         return c;
      end
      for (i = 0; i < 3; i++) begin
         u[i] = $urandom_range(0, 32767) - 16384;
         v[i] = (kind < 4) ? 0 : $urandom_range(0, 32767) - 16384;
      end
      for (i = 0; i < 3; i++) begin
         for (j = i; j < 3; j++) begin
            s = -(u[i] * u[j] + v[i] * v[j]);
            if (kind == 6 && i != j) s = 0;
            a = (i == j) ? 0 : $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            c[i][j] = s + a;
            c[j][i] = s - a;
         end
      end
      if (kind >= 7) begin
         i = $urandom_range(0, 2);
         j = $urandom_range(0, 2);
         c[i][j] = c[i][j] + (($urandom_range(0, 1) != 0) ? 1 : -1);
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Sends one cell; valid stays high afterwards so back-to-back words
   // never see a low-high pair in one time step.
   task automatic send_cell(input cell_type c);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            req_d[i][j] <= c[i][j];
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(converging_verdict(c));
   endtask

   // Stops sending and waits until every verdict is back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CHECK_ENABLE: cfg_enable       = value[0];
         CSR_INV_WIDTH_X:  cfg_inv_width[0] = value;
         CSR_INV_WIDTH_Y:  cfg_inv_width[1] = value;
         CSR_INV_WIDTH_Z:  cfg_inv_width[2] = value;
         default: ;
      endcase
   endtask

   task automatic write_widths(input logic [31:0] wx, input logic [31:0] wy,
                               input logic [31:0] wz);
      write_reg(CSR_INV_WIDTH_X, wx);
      write_reg(CSR_INV_WIDTH_Y, wy);
      write_reg(CSR_INV_WIDTH_Z, wz);
   endtask

   // result side: a fresh stall length for every word
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // ---------------------------------------------------------------------
   // Checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("converging: no cell outstanding, actual %0b", rsp_converging);
            failures++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_converging !== want) begin
               $error("converging: expected %0b, actual %0b", want, rsp_converging);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset state: check disabled, anything passes
   task automatic test_bypass();
      send_cell(uniform_cell(32'h7FFF_FFFF));
      send_cell(uniform_cell(32'h8000_0000));
      send_cell(random_cell());
   endtask

   task automatic test_special_tensors();
      cell_type c;
      drain_pipeline();
      write_reg(CSR_CHECK_ENABLE, 32'd1);
      send_cell(uniform_cell('0));
      send_cell(uniform_cell(32'h7FFF_FFFF));
      // rank one, all entries negative: every 2x2 minor and the determinant are zero
      send_cell(uniform_cell(32'h8000_0000));
      send_cell(uniform_cell(32'hFFFF_FFFF));
      // positive diagonal entry
      c = '0;
      c[0][0] = 32'h0001_0000;
      c[1][1] = -32'sh0001_0000;
      c[2][2] = -32'sh0001_0000;
      send_cell(c);
      // zero diagonal entry with a shear in its row
      c = '0;
      c[1][1] = -1;
      c[2][2] = -1;
      c[0][1] = 1;
      send_cell(c);
      // pure rotation: the symmetric part vanishes
      c = '0;
      c[0][1] = 32'h1234_5678;
      c[1][0] = -32'sh1234_5678;
      c[1][2] = 32'h7FFF_FFFF;
      c[2][1] = 32'h8000_0001;
      send_cell(c);
      // every 1x1 and 2x2 minor holds, only the determinant fails
      c = '0;
      c[0][0] = -1; c[1][1] = -1; c[2][2] = -1;
      c[0][1] = -1; c[1][0] = -1;
      c[1][2] = -1; c[2][1] = -1;
      send_cell(c);
      // same with the corner shear removed: semidefinite, passes
      c[1][2] = 0; c[2][1] = 0;
      send_cell(c);
   endtask

   task automatic test_width_extremes();
      cell_type c;
      drain_pipeline();
      write_widths('0, '0, '0);
      send_cell(uniform_cell(32'h7FFF_FFFF));
      send_cell(random_cell());
      drain_pipeline();
      write_widths('1, '1, '1);
      send_cell(uniform_cell(32'h8000_0000));
      send_cell(uniform_cell(32'h7FFF_FFFF));
      c = uniform_cell(32'h8000_0000);
      c[0][1] = 32'h7FFF_FFFF;
      c[2][0] = 32'h7FFF_FFFF;
      send_cell(c);
      drain_pipeline();
      write_widths(32'h0000_0001, '1, 32'h0001_0000);
      send_cell(uniform_cell(32'h8000_0000));
   endtask

   // only bit zero of the enable register counts
   task automatic test_register_masking();
      drain_pipeline();
      write_reg(CSR_CHECK_ENABLE, 32'hFFFF_FFFE);
      send_cell(uniform_cell(32'h0001_0000));
      drain_pipeline();
      write_reg(CSR_CHECK_ENABLE, 32'h8000_0003);
      send_cell(uniform_cell(32'h0001_0000));
   endtask

   task automatic test_random_flow(input int count, input bit enable, input logic [31:0] wx,
                                   input logic [31:0] wy, input logic [31:0] wz,
                                   input int pct);
      drain_pipeline();
      write_reg(CSR_CHECK_ENABLE, {31'($urandom()), enable});
      write_widths(wx, wy, wz);
      idle_pct = pct;
      for (int k = 0; k < count; k++) begin
         // halfway through, the sender holds off until the pipeline is empty
         if (k == count / 2) drain_pipeline();
         send_cell(random_cell());
      end
   endtask

   initial begin
      logic [31:0] w;
      reset       = 1'b1;
      req_valid   = 1'b0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            req_d[i][j] = '0;
      csr_write   = 1'b0;
      csr_index   = CSR_CHECK_ENABLE;
      csr_data    = '0;
      cfg_enable  = 1'b0;
      for (int j = 0; j < 3; j++) cfg_inv_width[j] = INV_WIDTH_RESET;
      failures    = 0;
      cycle_count = 0;
      idle_pct    = 50;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bypass();
      test_special_tensors();
      test_width_extremes();
      test_register_masking();

      test_random_flow(80, 1'b1, INV_WIDTH_RESET, INV_WIDTH_RESET, INV_WIDTH_RESET, 50);
      w = $urandom();
      test_random_flow(80, 1'b1, w, w, w, 0);
      test_random_flow(70, 1'b1, $urandom(), $urandom(), $urandom(), 100);
      test_random_flow(70, 1'b1, '1, '1, '1, 50);
      test_random_flow(50, 1'b1, '0, $urandom_range(1, 32'h0004_0000),
                       $urandom_range(1, 32'h0004_0000), 50);
      test_random_flow(50, 1'b0, $urandom(), $urandom(), $urandom(), 30);
      test_random_flow(50, 1'b1, 32'd1, 32'd1, 32'd1, 50);

      drain_pipeline();
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
